// ===== hw/rtl/sfb_pkg.sv =====
// Shared types, protocol codes and sizing helpers for the serial file block server.
`default_nettype none

package sfb_pkg;

    // Protocol bytes
    localparam logic [7:0] CODE_OPEN     = 8'h8A;
    localparam logic [7:0] CODE_BLOCK    = 8'h97;
    localparam logic [7:0] CODE_ACK      = 8'hC8;
    localparam logic [7:0] HDR_NOT_FOUND = 8'hFF;
    localparam logic [7:0] HDR_MACHINE   = 8'h02;
    localparam logic [7:0] PAD_CHAR      = 8'h20;

    // Block geometry: 128 data bytes, read as 16 rows of 8 bytes
    localparam int BLOCK_BYTES     = 128;
    localparam int ROW_BYTES       = 8;
    localparam int BLOCK_ROWS      = BLOCK_BYTES / ROW_BYTES;
    localparam int IMAGE_BYTES_DEF = 65536;
    localparam int CALC_W          = 24;

    // Reply kinds handed from the parser to the reply sequencer
    localparam logic [1:0] RPL_ECHO  = 2'd0;
    localparam logic [1:0] RPL_NAME  = 2'd1;
    localparam logic [1:0] RPL_BLOCK = 2'd2;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_NAME    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_SIZE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_PRESENT = 2'd2;

    localparam logic [63:0] NAME_RESET = 64'h2020202020202020;

    typedef struct packed {
        logic        func;
        logic [7:0]  byte_value;
        logic [15:0] load_address;
    } in_item_t;

    typedef struct packed {
        logic [63:0] tx_bytes;
        logic [3:0]  tx_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  echo_byte;
        logic        found;
        logic [15:0] block;
    } reply_cmd_t;

    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [7:0]  data;
    } store_wr_t;

    // Number of 8-byte rows needed for an image of the given size
    function automatic int image_rows(input int bytes);
        return (bytes + ROW_BYTES - 1) / ROW_BYTES;
    endfunction

    // Address bits for a memory of the given depth, at least one
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [sfb_pkg::addr_bits(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [sfb_pkg::addr_bits(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);
    import sfb_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_store.sv =====
// File image store: eight byte-wide banks, written a byte at a time, read a row of 8 at a time.
`default_nettype none

module sfb_store #(
    parameter int IMAGE_BYTES = sfb_pkg::IMAGE_BYTES_DEF
) (
    input  wire logic                                       clk,
    input  wire sfb_pkg::store_wr_t                         wr,
    input  wire logic                                       rd_en,
    input  wire logic [sfb_pkg::addr_bits(sfb_pkg::image_rows(IMAGE_BYTES))-1:0] rd_row,
    output logic      [63:0]                                rd_data
);
    import sfb_pkg::*;

    localparam int ROWS  = image_rows(IMAGE_BYTES);
    localparam int ROW_W = addr_bits(ROWS);

    logic             in_range;
    logic [ROW_W-1:0] wr_row;

    // Drop writes beyond the image
    assign in_range = ({16'h0000, wr.addr} < 32'(IMAGE_BYTES));
    assign wr_row   = ROW_W'(wr.addr >> 3);

    for (genvar b = 0; b < ROW_BYTES; b++)
    begin : g_bank
        sfb_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (wr.en && in_range && (wr.addr[2:0] == 3'(b))),
            .waddr (wr_row),
            .wdata (wr.data),
            .re    (rd_en),
            .raddr (rd_row),
            .rdata (rd_data[8*b +: 8])
        );
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_parse.sv =====
// Request parser: tracks the link protocol and issues reply commands and store writes.
`default_nettype none

module sfb_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire sfb_pkg::in_item_t   in_data,
    input  wire logic [63:0]         image_name,
    input  wire logic                image_present,
    output sfb_pkg::reply_cmd_t      cmd,
    output sfb_pkg::store_wr_t       store_wr
);
    import sfb_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_BLOCK = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  xor_reg, xor_next;
    logic [63:0] name_reg, name_next;
    logic [15:0] blk_reg, blk_next;
    logic        open_reg, open_next;
    logic [7:0]  b;
    logic        found;

    assign b     = in_data.byte_value;
    assign found = image_present && (name_reg[7:0] != 8'h00) &&
                   (name_reg != {8{PAD_CHAR}}) && (name_reg == image_name);

    // Step the protocol on each accepted transaction
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        name_next  = name_reg;
        blk_next   = blk_reg;
        open_next  = open_reg;
        cmd        = '0;
        store_wr   = '0;

        if (accept)
        begin
            if (in_data.func)
            begin
                store_wr.en   = 1'b1;
                store_wr.addr = in_data.load_address;
                store_wr.data = b;
            end
            else
            begin
                case (phase_reg)
                    PH_NAME:
                    begin
                        xor_next = xor_reg ^ b;
                        if (cnt_reg < 4'd8)
                        begin
                            name_next[{cnt_reg[2:0], 3'b000} +: 8] = b;
                            cnt_next = cnt_reg + 4'd1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = 4'd0;
                            if (xor_next == 8'h00)
                            begin
                                open_next = found;
                                cmd.valid = 1'b1;
                                cmd.kind  = RPL_NAME;
                                cmd.found = found;
                            end
                        end
                    end
                    PH_BLOCK:
                    begin
                        xor_next = xor_reg ^ b;
                        if (cnt_reg < 4'd2)
                        begin
                            blk_next = {blk_reg[7:0], b};
                            cnt_next = cnt_reg + 4'd1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = 4'd0;
                            if (xor_next == 8'h00)
                            begin
                                cmd.valid = 1'b1;
                                cmd.kind  = RPL_BLOCK;
                                cmd.block = blk_reg;
                            end
                        end
                    end
                    default:
                    begin
                        // Idle: echo the request code and pick the next phase
                        cnt_next = 4'd0;
                        xor_next = 8'h00;
                        if (b == CODE_OPEN)
                        begin
                            open_next  = 1'b0;
                            name_next  = '0;
                            phase_next = PH_NAME;
                        end
                        else if ((b == CODE_BLOCK) && open_reg)
                        begin
                            blk_next   = '0;
                            phase_next = PH_BLOCK;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                        cmd.valid     = 1'b1;
                        cmd.kind      = RPL_ECHO;
                        cmd.echo_byte = b;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            xor_reg   <= '0;
            name_reg  <= '0;
            blk_reg   <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            name_reg  <= name_next;
            blk_reg   <= blk_next;
            open_reg  <= open_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_reply.sv =====
// Reply sequencer: builds echo, header and block replies and drives the output register.
`default_nettype none

module sfb_reply #(
    parameter int IMAGE_BYTES = sfb_pkg::IMAGE_BYTES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sfb_pkg::reply_cmd_t     cmd,
    input  wire logic [16:0]             image_size,
    output logic                         rd_en,
    output logic [sfb_pkg::addr_bits(sfb_pkg::image_rows(IMAGE_BYTES))-1:0] rd_row,
    input  wire logic [63:0]             rd_data,
    output logic                         busy,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output sfb_pkg::out_item_t           out_data
);
    import sfb_pkg::*;

    localparam int ROW_W = addr_bits(image_rows(IMAGE_BYTES));

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PEND   = 2'd1;
    localparam logic [1:0] ST_SETUP  = 2'd2;
    localparam logic [1:0] ST_STREAM = 2'd3;

    localparam logic [4:0] LAST_RESULT = 5'(BLOCK_ROWS);
    localparam logic [4:0] LAST_ROW    = 5'(BLOCK_ROWS - 1);

    logic [1:0]       st_reg, st_next;
    out_item_t        pend_reg, pend_next;
    logic [15:0]      blk_reg, blk_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [4:0]       k_reg, k_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [15:0]      carry_reg, carry_next;
    logic [7:0]       xor_reg, xor_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             out_free;
    logic             load;
    out_item_t        word;
    out_item_t        single;
    logic [7:0]       hdr;
    logic [15:0]      num;
    logic [CALC_W-1:0] start, size_in, size_lim, size, rem;
    logic [7:0]       count;
    logic [7:0]       md [ROW_BYTES];
    logic [7:0]       row_xor;

    assign out_free = !out_valid_reg || !out_stall;

    // Single-result replies: echo byte or name header
    always_comb
    begin
        hdr    = cmd.found ? HDR_MACHINE : HDR_NOT_FOUND;
        single = '0;
        single.last = 1'b1;
        if (cmd.kind == RPL_NAME)
        begin
            single.tx_bytes = {32'h0, hdr, 8'h00, hdr, CODE_ACK};
            single.tx_count = 4'd4;
        end
        else
        begin
            single.tx_bytes = {56'h0, cmd.echo_byte};
            single.tx_count = 4'd1;
        end
    end

    // Block start, clamped size and valid-byte count
    always_comb
    begin
        num      = {1'b0, blk_reg[15:8], 7'b0} | {8'h00, blk_reg[7:0]};
        start    = CALC_W'({num, 7'b0});
        size_in  = CALC_W'(image_size);
        size_lim = CALC_W'(IMAGE_BYTES);
        size     = (size_in > size_lim) ? size_lim : size_in;
        rem      = size - start;
        if (start >= size)
        begin
            count = 8'd0;
        end
        else if (rem > CALC_W'(BLOCK_BYTES))
        begin
            count = 8'(BLOCK_BYTES);
        end
        else
        begin
            count = rem[7:0];
        end
    end

    // Pad row bytes past the valid count with spaces
    always_comb
    begin
        row_xor = 8'h00;
        for (int j = 0; j < ROW_BYTES; j++)
        begin
            md[j]   = ({k_reg[3:0], 3'(j)} < cnt_reg) ? rd_data[8*j +: 8] : PAD_CHAR;
            row_xor = row_xor ^ md[j];
        end
    end

    // Sequence replies
    always_comb
    begin
        st_next    = st_reg;
        pend_next  = pend_reg;
        blk_next   = blk_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        carry_next = carry_reg;
        xor_next   = xor_reg;
        load       = 1'b0;
        word       = '0;
        rd_en      = 1'b0;
        rd_row     = row_reg;

        case (st_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.kind == RPL_BLOCK)
                    begin
                        blk_next = cmd.block;
                        st_next  = ST_SETUP;
                    end
                    else if (out_free)
                    begin
                        load = 1'b1;
                        word = single;
                    end
                    else
                    begin
                        pend_next = single;
                        st_next   = ST_PEND;
                    end
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    word    = pend_reg;
                    st_next = ST_IDLE;
                end
            end
            ST_SETUP:
            begin
                cnt_next = count;
                xor_next = count;
                k_next   = 5'd0;
                rd_en    = 1'b1;
                rd_row   = ROW_W'(start >> 3);
                row_next = ROW_W'(start >> 3) + ROW_W'(1);
                st_next  = ST_STREAM;
            end
            default:
            begin
                // Stream: one row of data in hand per result
                if (out_free)
                begin
                    load = 1'b1;
                    if (k_reg == LAST_RESULT)
                    begin
                        word.tx_bytes = {40'h0, xor_reg, carry_reg};
                        word.tx_count = 4'd3;
                        word.last     = 1'b1;
                        st_next       = ST_IDLE;
                    end
                    else
                    begin
                        if (k_reg == 5'd0)
                        begin
                            word.tx_bytes = {md[5], md[4], md[3], md[2], md[1], md[0],
                                             cnt_reg, CODE_ACK};
                        end
                        else
                        begin
                            word.tx_bytes = {md[5], md[4], md[3], md[2], md[1], md[0],
                                             carry_reg};
                        end
                        word.tx_count = 4'd8;
                        word.last     = 1'b0;
                        carry_next    = {md[7], md[6]};
                        xor_next      = xor_reg ^ row_xor;
                        k_next        = k_reg + 5'd1;
                        if (k_reg < LAST_ROW)
                        begin
                            rd_en    = 1'b1;
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                end
            end
        endcase
    end

    // Output register: load a new result or drop the taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = word;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        blk_reg      <= blk_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        row_reg      <= row_next;
        carry_reg    <= carry_next;
        xor_reg      <= xor_next;
        out_data_reg <= out_data_next;
    end

    assign busy      = (st_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_file_block_server.sv =====
// Top level of the serial file block server: configuration registers, parser, store, replies.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data  (func, byte_value, load_address)
//   out      output     out_valid / out_stall out_data (tx_bytes, tx_count, last)
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// A load write or a link byte with no or one result is taken without a setup state; a new
// transaction is taken while a single result still waits in the output register.
// A block reply has a setup state, then one result per cycle while out_stall is low, as the
// eight-bank image store delivers one 8-byte row per result.
// Reset clears protocol and sequencer state; the image store has no reset and no clearing pass.
// out_stall holds the output register and pauses the store reads; in_stall is high
// while a reply is being sequenced.
`default_nettype none

module serial_file_block_server #(
    parameter int IMAGE_BYTES = sfb_pkg::IMAGE_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire sfb_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output sfb_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sfb_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data
);
    import sfb_pkg::*;

    localparam int ROW_W = addr_bits(image_rows(IMAGE_BYTES));

    logic [63:0]      image_name_reg;
    logic [16:0]      image_size_reg;
    logic             image_present_reg;
    logic             accept;
    logic             busy;
    reply_cmd_t       cmd;
    store_wr_t        store_wr;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [63:0]      rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_name_reg    <= NAME_RESET;
            image_size_reg    <= '0;
            image_present_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_NAME:    image_name_reg    <= cfg_data;
                REG_IMAGE_SIZE:    image_size_reg    <= cfg_data[16:0];
                REG_IMAGE_PRESENT: image_present_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Take a transaction only while no reply is in progress
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    sfb_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_data       (in_data),
        .image_name    (image_name_reg),
        .image_present (image_present_reg),
        .cmd           (cmd),
        .store_wr      (store_wr)
    );

    sfb_store #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    sfb_reply #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_reply (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .image_size (image_size_reg),
        .rd_en      (rd_en),
        .rd_row     (rd_row),
        .rd_data    (rd_data),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_checker.sv =====
// Port-level checker for the serial file block server, bound to the top level.
`default_nettype none

module sfb_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire sfb_pkg::in_item_t             in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire sfb_pkg::out_item_t            out_data
);
    import sfb_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Hold a stalled input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input changed");

    // Keep the byte count in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tx_count >= 4'd1) && (out_data.tx_count <= 4'd8))
        else $error("tx_count out of range");

    // Zero the bytes past a one-byte echo
    a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.tx_count == 4'd1) |-> out_data.tx_bytes[63:8] == 56'h0)
        else $error("echo carries stray bytes");

    // Block no input while a multi-result reply is under way
    a_block_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input taken during block reply");

endmodule

bind serial_file_block_server sfb_checker u_sfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== dv/serial_file_block_server_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the serial file block server: queued stimulus, predictor, checks.

module serial_file_block_server_tb;
    import sfb_pkg::*;

    localparam int STORE_BYTES   = IMAGE_BYTES_DEF;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PLAN          = 0;
    localparam int LIVE          = 1;

    localparam logic FUNC_LINK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // File names, first character in the low byte
    localparam logic [63:0] NAME_MAIN  = 64'h2041544144_4D4F52;
    localparam logic [63:0] NAME_SHORT = 64'h2020202020202041;

    typedef enum logic [1:0] {LINK_IDLE, LINK_NAME, LINK_BLOCK} link_phase_e;

    typedef struct packed {
        link_phase_e phase;
        logic [3:0]  got;
        logic [7:0]  xsum;
        logic [63:0] name_acc;
        logic [15:0] blk_sel;
        logic        opened;
    } link_state_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_IMAGE_NAME;
    logic [63:0]          cfg_data  = '0;

    // Register copies used by the predictor
    logic [63:0] file_name  = NAME_RESET;
    logic [16:0] file_size  = '0;
    logic        file_ready = 1'b0;

    // Index PLAN follows the queue as it is filled, LIVE follows accepted transactions
    link_state_t link_st [2];
    logic [7:0]  image_copy [STORE_BYTES];
    bit          loaded [STORE_BYTES];
    out_item_t   reply_buf [17];
    out_item_t   tx_due [$];
    in_item_t    pending [$];

    int items_queued = 0;
    int items_taken  = 0;
    int fail_count   = 0;
    int quiet        = 0;
    bit gaps_on      = 1'b1;
    bit in_fire      = 1'b0;

    serial_file_block_server uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Start address and valid byte count of a requested block
    function automatic int unsigned block_span(input logic [15:0] sel,
                                               output int unsigned start);
        int unsigned lim;
        start = ({17'd0, sel[15:8], 7'd0} | {24'd0, sel[7:0]}) * BLOCK_BYTES;
        lim = (file_size > STORE_BYTES) ? STORE_BYTES : file_size;
        if (start >= lim)
            return 0;
        return (lim - start > BLOCK_BYTES) ? BLOCK_BYTES : lim - start;
    endfunction

    // Serve one transaction on one side of the model; fill reply_buf, return result count
    function automatic int serve_byte(input int side, input in_item_t it);
        link_state_t st;
        logic [7:0]  seq [BLOCK_BYTES + 3];
        logic [7:0]  b;
        logic [7:0]  hdr;
        logic [7:0]  xr;
        logic [63:0] word;
        logic        found;
        int unsigned start;
        int unsigned span;
        int          n;
        int          nres;
        int          i;
        int          c;
        st = link_st[side];
        b = it.byte_value;
        n = 0;
        nres = 0;
        // Store writes touch the image only
        if (it.func == FUNC_LOAD) begin
            if (side == LIVE)
                image_copy[it.load_address] = b;
            else
                loaded[it.load_address] = 1'b1;
            return 0;
        end
        case (st.phase)
            LINK_NAME: begin
                st.xsum ^= b;
                if (st.got < 8) begin
                    st.name_acc[8 * st.got +: 8] = b;
                    st.got++;
                end else begin
                    st.phase = LINK_IDLE;
                    st.got = '0;
                    if (st.xsum == 8'h00) begin
                        found = file_ready && st.name_acc[7:0] != 8'h00 &&
                                st.name_acc != NAME_RESET && st.name_acc == file_name;
                        hdr = found ? HDR_MACHINE : HDR_NOT_FOUND;
                        st.opened = found;
                        seq[0] = CODE_ACK;
                        seq[1] = hdr;
                        seq[2] = 8'h00;
                        seq[3] = hdr;
                        n = 4;
                    end
                end
            end
            LINK_BLOCK: begin
                st.xsum ^= b;
                if (st.got < 2) begin
                    st.blk_sel = {st.blk_sel[7:0], b};
                    st.got++;
                end else begin
                    st.phase = LINK_IDLE;
                    st.got = '0;
                    if (st.xsum == 8'h00) begin
                        span = block_span(st.blk_sel, start);
                        seq[0] = CODE_ACK;
                        seq[1] = span[7:0];
                        xr = span[7:0];
                        for (i = 0; i < BLOCK_BYTES; i++) begin
                            seq[2 + i] = (i < span) ? image_copy[start + i] : PAD_CHAR;
                            xr ^= seq[2 + i];
                        end
                        seq[BLOCK_BYTES + 2] = xr;
                        n = BLOCK_BYTES + 3;
                    end
                end
            end
            default: begin
                // Echo the request code and pick the next phase
                st.got = '0;
                st.xsum = '0;
                if (b == CODE_OPEN) begin
                    st.opened = 1'b0;
                    st.name_acc = '0;
                    st.phase = LINK_NAME;
                end else if (b == CODE_BLOCK && st.opened) begin
                    st.blk_sel = '0;
                    st.phase = LINK_BLOCK;
                end else begin
                    st.phase = LINK_IDLE;
                end
                seq[0] = b;
                n = 1;
            end
        endcase
        // Pack up to eight bytes per result
        for (i = 0; i < n; i += 8) begin
            word = '0;
            for (c = 0; c < 8 && i + c < n; c++)
                word[8 * c +: 8] = seq[i + c];
            reply_buf[nres].tx_bytes = word;
            reply_buf[nres].tx_count = c[3:0];
            reply_buf[nres].last = (i + 8 >= n);
            nres++;
        end
        link_st[side] = st;
        return nres;
    endfunction

    task automatic push_item(input in_item_t it);
        void'(serve_byte(PLAN, it));
        pending.push_back(it);
        items_queued++;
    endtask

    task automatic push_load(input logic [15:0] addr, input logic [7:0] val);
        in_item_t it;
        it.func = FUNC_LOAD;
        it.byte_value = val;
        it.load_address = addr;
        push_item(it);
    endtask

    task automatic push_link(input logic [7:0] b);
        in_item_t    it;
        int unsigned start;
        int unsigned span;
        int unsigned i;
        // Write every store byte a good block request is about to read, if never written
        if (link_st[PLAN].phase == LINK_BLOCK && link_st[PLAN].got == 2 &&
            (link_st[PLAN].xsum ^ b) == 8'h00) begin
            span = block_span(link_st[PLAN].blk_sel, start);
            for (i = 0; i < span; i++)
                if (!loaded[start + i])
                    push_load(16'(start + i), 8'($urandom_range(0, 255)));
        end
        it.func = FUNC_LINK;
        it.byte_value = b;
        it.load_address = 16'($urandom_range(0, 65535));
        push_item(it);
    endtask

    task automatic send_open(input logic [63:0] nm, input bit good);
        logic [7:0] ck;
        int         i;
        ck = '0;
        push_link(CODE_OPEN);
        for (i = 0; i < 8; i++) begin
            push_link(nm[8 * i +: 8]);
            ck ^= nm[8 * i +: 8];
        end
        push_link(good ? ck : ck ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic send_block(input logic [7:0] b0, input logic [7:0] b1, input bit good);
        push_link(CODE_BLOCK);
        push_link(b0);
        push_link(b1);
        push_link(good ? (b0 ^ b1) : (b0 ^ b1 ^ 8'($urandom_range(1, 255))));
    endtask

    // Pick a block number: the first, the last, or one of the two just past the end of the image
    task automatic random_block(input bit good);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [14:0] num;
        int unsigned lim;
        int unsigned rows;
        lim = (file_size > STORE_BYTES) ? STORE_BYTES : file_size;
        rows = (lim + BLOCK_BYTES - 1) / BLOCK_BYTES;
        case ($urandom_range(0, 3))
            0: num = 15'd0;
            1: num = (rows == 0) ? 15'd0 : 15'(rows - 1);
            default: num = 15'(rows + $urandom_range(0, 1));
        endcase
        b0 = num[14:7];
        b1 = {1'b0, num[6:0]};
        // Occasionally use raw bytes so the overlapping bit and large numbers appear
        if ($urandom_range(0, 3) == 0) begin
            b0 = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(0, 255));
        end
        send_block(b0, b1, good);
    endtask

    task automatic random_request();
        logic [63:0] nm;
        int          pick;
        int          pos;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if (!link_st[PLAN].opened && $urandom_range(0, 1) == 1)
                send_open(file_name, 1'b1);
            random_block($urandom_range(0, 99) < 90);
        end else if (pick < 70) begin
            case ($urandom_range(0, 6))
                3: begin
                    nm = file_name;
                    pos = $urandom_range(0, 63);
                    nm[pos] = ~nm[pos];
                end
                4: nm = NAME_RESET;
                5: nm = {file_name[63:8], 8'h00};
                6: nm = {$urandom, $urandom};
                default: nm = file_name;
            endcase
            send_open(nm, $urandom_range(0, 99) < 85);
        end else if (pick < 85) begin
            push_link(8'($urandom_range(0, 255)));
        end else begin
            push_load(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Hold until every queued transaction is taken and every result is back
    task automatic settle();
        while (items_taken != items_queued || tx_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_image(input logic [63:0] nm, input logic [16:0] sz, input logic pr);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_NAME;
        cfg_data  <= nm;
        @(negedge clk);
        cfg_index <= REG_IMAGE_SIZE;
        cfg_data  <= 64'(sz);
        @(negedge clk);
        cfg_index <= REG_IMAGE_PRESENT;
        cfg_data  <= 64'(pr);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        file_name  = nm;
        file_size  = sz;
        file_ready = pr;
    endtask

    task automatic run_phase(input logic [63:0] nm, input logic [16:0] sz, input logic pr,
                             input int requests, input bit calm);
        int i;
        settle();
        set_image(nm, sz, pr);
        gaps_on = !calm;
        for (i = 0; i < requests; i++)
            random_request();
    endtask

    // Present queued transactions, holding each until it is taken
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (pending.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 20)) begin
                in_data  <= pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        in_fire = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
        out_stall <= gaps_on && ($urandom_range(0, 99) < 20);

    // Predict results of each accepted input transaction
    always @(posedge clk) begin
        int n;
        int k;
        if (rst_n && in_valid && !in_stall) begin
            in_fire = 1'b1;
            items_taken++;
            n = serve_byte(LIVE, in_data);
            for (k = 0; k < n; k++)
                tx_due.push_back(reply_buf[k]);
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge clk) begin
        out_item_t exp_item;
        if (rst_n && out_valid && !out_stall) begin
            if (tx_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result bytes=%h count=%0d last=%0b", $time,
                         out_data.tx_bytes, out_data.tx_count, out_data.last);
            end else begin
                exp_item = tx_due.pop_front();
                if (out_data.tx_bytes !== exp_item.tx_bytes ||
                    out_data.tx_count !== exp_item.tx_count ||
                    out_data.last !== exp_item.last) begin
                    fail_count++;
                    $display("%0t: result mismatch: expected bytes=%h count=%0d last=%0b",
                             $time, exp_item.tx_bytes, exp_item.tx_count, exp_item.last);
                    $display("%0t:                  actual   bytes=%h count=%0d last=%0b",
                             $time, out_data.tx_bytes, out_data.tx_count, out_data.last);
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
    end

    // End the run when no transaction moves for too long
    initial begin
        while (quiet < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int i;
        link_st[PLAN] = '0;
        link_st[LIVE] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unknown codes, block request with no file, store extremes, good and bad
        set_image(NAME_MAIN, 17'd136, 1'b1);
        push_link(8'h00);
        push_link(8'hFF);
        push_link(CODE_BLOCK);
        push_load(16'h0000, 8'hFF);
        push_load(16'hFFFF, 8'h00);
        send_open(NAME_MAIN, 1'b1);
        send_block(8'h00, 8'h00, 1'b1);
        send_block(8'h00, 8'h02, 1'b0);

        // Random requests; pause once mid-phase until all results are back
        for (i = 0; i < 5; i++)
            random_request();
        settle();
        for (i = 0; i < 5; i++)
            random_request();

        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 17'd65536, 1'b1, 4, 1'b0);
        run_phase(NAME_SHORT, 17'd0, 1'b1, 4, 1'b0);
        run_phase(64'h0, 17'd129, 1'b1, 4, 1'b0);
        run_phase(NAME_MAIN, 17'd127, 1'b0, 4, 1'b0);
        run_phase({$urandom, $urandom}, 17'($urandom_range(1, 136)), 1'b1, 10, 1'b1);
        run_phase(NAME_MAIN, 17'd136, 1'b1, 3, 1'b0);

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== serial_file_block_server.f =====
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_ram.sv
hw/rtl/sfb_store.sv
hw/rtl/sfb_parse.sv
hw/rtl/sfb_reply.sv
hw/rtl/serial_file_block_server.sv
hw/rtl/sfb_checker.sv
dv/serial_file_block_server_tb.sv
